// ----- src/lprfp_pkg.sv -----
// Types, codes and decode helpers shared by the load port reply frame parser.
// No dependencies; every other file imports this package.
package lprfp_pkg;

    typedef struct packed {
        logic [7:0] character;
        logic       last_char;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  frame_result;
        logic [31:0] primary_word;
        logic [31:0] cross_slot_word;
        logic [31:0] double_slot_word;
        logic [11:0] indicator_states;
        logic [1:0]  door_state;
        logic [1:0]  pod_position;
        logic [1:0]  carrier_state;
        logic [1:0]  clamp_state;
    } t_out_word;

    // Line state with the current character folded in; pos is the position of the current character.
    typedef struct packed {
        logic [4:0]  pos;
        logic [7:0]  letter;
        logic [31:0] word_first;
        logic [31:0] word_second;
        logic [31:0] word_third;
    } t_line;

    localparam logic [4:0] POS_MAX        = 5'd31;
    localparam logic [4:0] LAST_POS_SHORT = 5'd8;   // 9-character frames
    localparam logic [4:0] LAST_POS_MAP   = 5'd26;  // 27-character frames

    localparam logic [7:0] CHAR_S = 8'h53;
    localparam logic [7:0] CHAR_I = 8'h49;
    localparam logic [7:0] CHAR_M = 8'h4d;

    localparam logic [1:0] FRAME_STATUS    = 2'd0;
    localparam logic [1:0] FRAME_INDICATOR = 2'd1;

    localparam logic [1:0] RES_OK     = 2'd0;
    localparam logic [1:0] RES_LENGTH = 2'd1;
    localparam logic [1:0] RES_LETTER = 2'd2;

    localparam logic [1:0] ST_UNKNOWN = 2'd0;
    localparam logic [1:0] ST_YES     = 2'd1;
    localparam logic [1:0] ST_NO      = 2'd2;

    localparam logic [3:0] NIB_MASK = 4'h0f;
    localparam logic [3:0] NIB_ON    = 4'h1;
    localparam logic [3:0] NIB_BLINK = 4'h2;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (c >= 8'h30 && c <= 8'h39) begin
                d = c - 8'h30;
            end else if (c >= 8'h41 && c <= 8'h46) begin
                d = c - 8'h37;
            end else if (c >= 8'h61 && c <= 8'h66) begin
                d = c - 8'h57;
            end
            hex_value = d[3:0] & NIB_MASK;
        end
    endfunction

    function automatic logic [1:0] pair_state(input logic yes_bit, input logic no_bit);
        begin
            if (yes_bit && !no_bit) begin
                pair_state = ST_YES;
            end else if (!yes_bit && no_bit) begin
                pair_state = ST_NO;
            end else begin
                pair_state = ST_UNKNOWN;
            end
        end
    endfunction

endpackage

// ----- src/load_port_reply_frame_parser.sv -----
// Top level of the load port reply frame parser: input register, line
// accumulator, frame decode and result register. Depends on lprfp_pkg,
// lprfp_accum and lprfp_eval.
//
//   channel | valid      | ready       | payload
//   --------+------------+-------------+----------------------------
//   input   | i_in_valid | o_in_ready  | i_in_word  (t_in_word)
//   result  | o_out_valid| i_out_ready | o_out_word (t_out_word)
//   config  | i_cfg_valid| o_cfg_ready | i_cfg_data (expected frame)
//
// One character per cycle is taken while no last character waits on a
// stalled result; it is registered, then folded into the line state, and a
// last character loads the result register in the cycle that folds it in.
// A stalled result holds only a last character in the input register; other
// characters keep flowing. Synchronous active-low reset clears the line state
// and both valid flags and sets the expected frame to the status frame.
module load_port_reply_frame_parser
    import lprfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_word   i_in_word,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_word  o_out_word,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_data
);

    logic      r_in_valid;
    t_in_word  r_in;
    logic      r_out_valid;
    t_out_word r_out;
    logic [1:0] r_expected;
    logic      out_free;
    logic      go;
    t_line     line;
    t_out_word result;

    assign out_free    = !r_out_valid || i_out_ready;
    assign go          = r_in_valid && (!r_in.last_char || out_free);
    assign o_in_ready  = !r_in_valid || go;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    lprfp_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_char  (r_in),
        .o_line  (line)
    );

    lprfp_eval u_eval (
        .i_expected (r_expected),
        .i_line     (line),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_expected  <= FRAME_STATUS;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (go && r_in.last_char) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_expected <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_word;
        end
        if (go && r_in.last_char) begin
            r_out <= result;
        end
    end

    // A rejected frame carries nothing but its result code.
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.frame_result != RES_OK) |->
        (o_out_word.primary_word == 32'h0 && o_out_word.cross_slot_word == 32'h0 &&
         o_out_word.double_slot_word == 32'h0 && o_out_word.indicator_states == 12'h0))
        else $error("rejected frame carries data");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && r_in.last_char) |=> o_out_valid)
        else $error("last character produced no result");

    a_result_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.frame_result == RES_OK ||
                         o_out_word.frame_result == RES_LENGTH ||
                         o_out_word.frame_result == RES_LETTER))
        else $error("result code out of range");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_in.last_char && r_out_valid && !i_out_ready))
        else $error("input stalled without a blocked result");

endmodule

// ----- src/lprfp_accum.sv -----
// Line accumulator: character count, leading letter and the three hex words.
// Depends on lprfp_pkg.
module lprfp_accum
    import lprfp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_go,
    input  t_in_word i_char,
    output t_line    o_line
);

    logic [4:0]  r_pos, n_pos;
    logic [7:0]  r_letter, n_letter;
    logic [31:0] r_w1, n_w1;
    logic [31:0] r_w2, n_w2;
    logic [31:0] r_w3, n_w3;
    logic [3:0]  hex;

    always_comb begin
        hex      = hex_value(i_char.character);
        n_letter = r_letter;
        n_w1     = r_w1;
        n_w2     = r_w2;
        n_w3     = r_w3;
        // Positions 9 and 18 are separators and are not decoded.
        if (r_pos == 5'd0) begin
            n_letter = i_char.character;
        end else if (r_pos >= 5'd1 && r_pos <= 5'd8) begin
            n_w1 = {r_w1[27:0], hex};
        end else if (r_pos >= 5'd10 && r_pos <= 5'd17) begin
            n_w2 = {r_w2[27:0], hex};
        end else if (r_pos >= 5'd19 && r_pos <= 5'd26) begin
            n_w3 = {r_w3[27:0], hex};
        end
        n_pos = (r_pos == POS_MAX) ? POS_MAX : r_pos + 5'd1;
    end

    assign o_line = '{pos: r_pos, letter: n_letter, word_first: n_w1,
                      word_second: n_w2, word_third: n_w3};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_letter <= '0;
            r_w1     <= '0;
            r_w2     <= '0;
            r_w3     <= '0;
        end else if (i_go) begin
            if (i_char.last_char) begin
                r_pos    <= '0;
                r_letter <= '0;
                r_w1     <= '0;
                r_w2     <= '0;
                r_w3     <= '0;
            end else begin
                r_pos    <= n_pos;
                r_letter <= n_letter;
                r_w1     <= n_w1;
                r_w2     <= n_w2;
                r_w3     <= n_w3;
            end
        end
    end

endmodule

// ----- src/lprfp_eval.sv -----
// Frame check and field decode of a completed line.
// Depends on lprfp_pkg.
module lprfp_eval
    import lprfp_pkg::*;
(
    input  logic [1:0] i_expected,
    input  t_line      i_line,
    output t_out_word  o_result
);

    logic [4:0]  want_pos;
    logic [7:0]  want_letter;
    logic [31:0] w;
    logic [3:0]  nib;
    logic [11:0] lamps;

    always_comb begin
        w = i_line.word_first;
        case (i_expected)
            FRAME_STATUS: begin
                want_pos    = LAST_POS_SHORT;
                want_letter = CHAR_S;
            end
            FRAME_INDICATOR: begin
                want_pos    = LAST_POS_SHORT;
                want_letter = CHAR_I;
            end
            default: begin
                want_pos    = LAST_POS_MAP;
                want_letter = CHAR_M;
            end
        endcase

        lamps = '0;
        for (int n = 0; n < 6; n++) begin
            nib = w[4*n +: 4];
            if ((nib & NIB_ON) != 4'h0) begin
                lamps[2*n +: 2] = ST_YES;
            end else if ((nib & NIB_BLINK) != 4'h0) begin
                lamps[2*n +: 2] = ST_NO;
            end
        end

        o_result = '0;
        // A saturated count never equals a valid last position.
        if (i_line.pos != want_pos) begin
            o_result.frame_result = RES_LENGTH;
        end else if (i_line.letter != want_letter) begin
            o_result.frame_result = RES_LETTER;
        end else begin
            o_result.frame_result = RES_OK;
            o_result.primary_word = w;
            case (i_expected)
                FRAME_STATUS: begin
                    o_result.door_state   = pair_state(w[2], w[3]);
                    o_result.pod_position = pair_state(w[11], w[12]);
                    o_result.clamp_state  = pair_state(w[9], w[10]);
                    o_result.carrier_state = (w[28] && w[29]) ? ST_YES :
                                             (!w[28] && !w[29]) ? ST_NO : ST_UNKNOWN;
                end
                FRAME_INDICATOR: begin
                    o_result.indicator_states = lamps;
                end
                default: begin
                    o_result.cross_slot_word  = i_line.word_second;
                    o_result.double_slot_word = i_line.word_third;
                end
            endcase
        end
    end

endmodule
